@@ design/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_FRONT      = 4'd4,
    CMD_BACK       = 4'd5,
    CMD_AT         = 4'd6,
    CMD_INSERT     = 4'd7,
    CMD_REMOVE     = 4'd8,
    CMD_CLEAR      = 4'd9,
    CMD_SIZE       = 4'd10
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

@@ design/ile_ram.sv @@
// ----------------------------------------------------------------------------
// ile_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed words with indexed insert and remove.
// ----------------------------------------------------------------------------
// One request at a time. Each request returns one response carrying a value,
// a status and the element count after the request. Elements sit front to
// back in a single-port-write RAM. Push_front and insert move the following
// elements one place, one RAM read and one write per cycle, through the exec
// and shift states; pop_front and remove pass through exec, read and shift.
// Push_back, clear, size and any rejected request go from exec straight to
// done; pop_back, peeks and reads pass through exec and read. A stalled
// response holds the engine in its done state. A request is taken only while
// the engine is idle; a finished response waits in the output register while
// the next request is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [ile_pkg::CMD_W-1:0]           cmd,
  input  logic [ile_pkg::POS_W-1:0]           position,
  input  logic signed [ile_pkg::DATA_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [ile_pkg::DATA_W-1:0]   result_value,
  output logic [ile_pkg::ST_W-1:0]            status,
  output logic [ile_pkg::CNT_W-1:0]           count
);
  import ile_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_READ  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state;
  logic [CW-1:0]       fill;
  cmd_t                op;
  logic [POS_W-1:0]    pos;
  logic [DATA_W-1:0]   word;
  logic [DATA_W-1:0]   res_value;
  status_t             res_status;
  logic [AW-1:0]       base;
  logic [AW-1:0]       ptr;
  logic [CW-1:0]       left;
  logic                up;
  logic                pend;
  logic [AW-1:0]       pend_addr;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;
  logic                full;
  logic                empty;
  logic [AW-1:0]       last;
  logic [AW-1:0]       rd_sel;
  logic                rd_ok;
  logic                rsp_free;

  assign pos_x    = XW'(pos);
  assign cnt_x    = XW'(fill);
  assign full     = (cnt_x >= XW'(CAPACITY));
  assign empty    = (fill == '0);
  assign last     = AW'(fill - 1'b1);
  assign rsp_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Read address and range check for the peek / pop / indexed read group
  always_comb begin
    rd_sel = AW'(pos_x);
    rd_ok  = (pos_x < cnt_x);
    case (op)
      CMD_POP_FRONT, CMD_FRONT: begin
        rd_sel = '0;
        rd_ok  = !empty;
      end
      CMD_POP_BACK, CMD_BACK: begin
        rd_sel = last;
        rd_ok  = !empty;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_sel;
    unique case (state)
      S_EXEC: begin
        if (op == CMD_PUSH_BACK && !full) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(fill);
          ram_wdata = word;
        end
        if ((op == CMD_POP_FRONT || op == CMD_POP_BACK || op == CMD_FRONT ||
             op == CMD_BACK || op == CMD_AT || op == CMD_REMOVE) && rd_ok) begin
          ram_re = 1'b1;
        end
      end
      S_SHIFT: begin
        ram_re    = (left != '0);
        ram_raddr = ptr;
        ram_we    = pend;
        // insert / push_front: last move done, drop the new word into the gap
        if (left == '0 && !pend && !up) begin
          ram_we    = 1'b1;
          ram_waddr = base;
          ram_wdata = word;
        end
      end
      default: ;
    endcase
  end

  ile_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a new response load in S_DONE takes priority over the drain
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= cmd_t'(cmd);
            pos   <= position;
            word  <= value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_value  <= '0;
          res_status <= ST_OK;
          pend       <= 1'b0;
          state      <= S_DONE;
          unique case (op)
            CMD_PUSH_BACK: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                fill <= fill + 1'b1;
              end
            end
            CMD_PUSH_FRONT, CMD_INSERT: begin
              if (op == CMD_INSERT && pos_x > cnt_x) begin
                res_status <= ST_RANGE;
              end else if (full) begin
                res_status <= ST_FULL;
              end else begin
                base  <= (op == CMD_INSERT) ? AW'(pos_x) : '0;
                ptr   <= last;
                left  <= (op == CMD_INSERT) ? CW'(cnt_x - pos_x) : fill;
                up    <= 1'b0;
                state <= S_SHIFT;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK, CMD_AT, CMD_REMOVE: begin
              if (rd_ok) begin
                base  <= rd_sel;
                state <= S_READ;
              end else begin
                res_status <= ST_RANGE;
              end
            end
            CMD_CLEAR: begin
              fill <= '0;
            end
            default: ;
          endcase
        end
        S_READ: begin
          res_value <= ram_rdata;
          state     <= S_DONE;
          case (op)
            CMD_POP_BACK: begin
              fill <= fill - 1'b1;
            end
            CMD_POP_FRONT, CMD_REMOVE: begin
              ptr   <= base + 1'b1;
              left  <= CW'(fill - CW'(base) - 1'b1);
              up    <= 1'b1;
              state <= S_SHIFT;
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          // read at ptr this cycle, write it one place over the next
          if (left != '0) begin
            ptr       <= up ? ptr + 1'b1 : ptr - 1'b1;
            pend_addr <= up ? ptr - 1'b1 : ptr + 1'b1;
            left      <= left - 1'b1;
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              fill  <= up ? fill - 1'b1 : fill + 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            result_value <= res_value;
            status       <= res_status;
            count        <= CNT_W'(fill);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_SHIFT)
    else $error("pending shift write outside shift state");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_free && res_status == ST_FULL) |-> full)
    else $error("full status with room left");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (XW'(ram_waddr) < XW'(CAPACITY)))
    else $error("RAM write beyond capacity");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_free) |=> (rsp_valid && state == S_IDLE))
    else $error("response not loaded");

endmodule
